>>> rtl/bmh_pkg.sv
package bmh_pkg;

  // field widths of the stream items and the register
  localparam int MAX_K_DEFAULT = 16;
  localparam int CAP_W         = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam int MODE_W        = 2;
  localparam int IDX_W         = 16;
  localparam int DIST_W        = 32;
  localparam int STAT_W        = 3;
  localparam int FILL_OUT_W    = 5;
  localparam int S_TDATA_W     = 48;
  localparam int M_TDATA_W     = 56;

  // one stored heap entry, index in the low bits as on the input stream
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DRAIN  = 2'd2
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_CLEARED   = 3'd0,
    ST_APPENDED  = 3'd1,
    ST_REPLACED  = 3'd2,
    ST_DISCARDED = 3'd3,
    ST_DRAINED   = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  // sequencer step addresses
  typedef enum logic [3:0] {
    U_IDLE  = 4'd0,
    U_CLR   = 4'd1,
    U_INS   = 4'd2,
    U_UPRD  = 4'd3,
    U_UPCMP = 4'd4,
    U_RTCMP = 4'd5,
    U_DNRD  = 4'd6,
    U_DNCMP = 4'd7,
    U_DRN   = 4'd8,
    U_DRRD  = 4'd9,
    U_DROUT = 4'd10
  } upc_t;

  // branch conditions
  typedef enum logic [3:0] {
    C_ALWAYS = 4'd0,
    C_IN     = 4'd1,
    C_APPEND = 4'd2,
    C_IZERO  = 4'd3,
    C_PLT    = 4'd4,
    C_RLT    = 4'd5,
    C_DNSWAP = 4'd6,
    C_EMPTY  = 4'd7,
    C_DLAST  = 4'd8
  } cond_t;

  // memory read issue
  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_ROOT   = 3'd1,
    RD_PARENT = 3'd2,
    RD_KIDS   = 3'd3,
    RD_SLOT   = 3'd4
  } rd_op_t;

  // memory write at the hole slot
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_X    = 2'd1,
    WR_PAR  = 2'd2,
    WR_BIG  = 2'd3
  } wr_op_t;

  // slot pointer update
  typedef enum logic [1:0] {
    IX_NONE = 2'd0,
    IX_ZERO = 2'd1,
    IX_FILL = 2'd2,
    IX_INC  = 2'd3
  } ix_op_t;

  typedef enum logic [1:0] {
    FA_NONE  = 2'd0,
    FA_CLEAR = 2'd1,
    FA_INC   = 2'd2
  } fill_op_t;

  // one control word
  typedef struct packed {
    cond_t    cond;
    upc_t     jmp;
    upc_t     nxt;
    logic     disp;
    rd_op_t   rd;
    wr_op_t   wr_hit;
    wr_op_t   wr_miss;
    ix_op_t   ia_hit;
    ix_op_t   ia_miss;
    fill_op_t fa_hit;
    logic     need_out;
    logic     emit_hit;
    logic     emit_miss;
    status_t  st_hit;
    status_t  st_miss;
    logic     drn;
  } uword_t;

  // control store
  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '0;
    unique case (pc)
      U_IDLE: begin
        w.cond = C_IN;
        w.disp = 1'b1;
        w.nxt  = U_IDLE;
      end
      U_CLR: begin
        w.cond     = C_ALWAYS;
        w.fa_hit   = FA_CLEAR;
        w.need_out = 1'b1;
        w.emit_hit = 1'b1;
        w.st_hit   = ST_CLEARED;
        w.jmp      = U_IDLE;
      end
      U_INS: begin
        w.cond   = C_APPEND;
        w.ia_hit = IX_FILL;
        w.fa_hit = FA_INC;
        w.jmp    = U_UPRD;
        w.rd     = RD_ROOT;
        w.nxt    = U_RTCMP;
      end
      U_UPRD: begin
        w.cond     = C_IZERO;
        w.wr_hit   = WR_X;
        w.need_out = 1'b1;
        w.emit_hit = 1'b1;
        w.st_hit   = ST_APPENDED;
        w.jmp      = U_IDLE;
        w.rd       = RD_PARENT;
        w.nxt      = U_UPCMP;
      end
      U_UPCMP: begin
        w.cond      = C_PLT;
        w.wr_hit    = WR_PAR;
        w.jmp       = U_UPRD;
        w.wr_miss   = WR_X;
        w.need_out  = 1'b1;
        w.emit_miss = 1'b1;
        w.st_miss   = ST_APPENDED;
        w.nxt       = U_IDLE;
      end
      U_RTCMP: begin
        w.cond      = C_RLT;
        w.ia_hit    = IX_ZERO;
        w.jmp       = U_DNRD;
        w.need_out  = 1'b1;
        w.emit_miss = 1'b1;
        w.st_miss   = ST_DISCARDED;
        w.nxt       = U_IDLE;
      end
      U_DNRD: begin
        w.cond = C_ALWAYS;
        w.rd   = RD_KIDS;
        w.jmp  = U_DNCMP;
      end
      U_DNCMP: begin
        w.cond      = C_DNSWAP;
        w.wr_hit    = WR_BIG;
        w.jmp       = U_DNRD;
        w.wr_miss   = WR_X;
        w.need_out  = 1'b1;
        w.emit_miss = 1'b1;
        w.st_miss   = ST_REPLACED;
        w.nxt       = U_IDLE;
      end
      U_DRN: begin
        w.cond     = C_EMPTY;
        w.need_out = 1'b1;
        w.emit_hit = 1'b1;
        w.st_hit   = ST_EMPTY;
        w.jmp      = U_IDLE;
        w.ia_miss  = IX_ZERO;
        w.nxt      = U_DRRD;
      end
      U_DRRD: begin
        w.cond = C_ALWAYS;
        w.rd   = RD_SLOT;
        w.jmp  = U_DROUT;
      end
      U_DROUT: begin
        w.cond      = C_DLAST;
        w.drn       = 1'b1;
        w.need_out  = 1'b1;
        w.emit_hit  = 1'b1;
        w.emit_miss = 1'b1;
        w.st_hit    = ST_DRAINED;
        w.st_miss   = ST_DRAINED;
        w.jmp       = U_IDLE;
        w.ia_miss   = IX_INC;
        w.nxt       = U_DRRD;
      end
      default: begin
        w.nxt = U_IDLE;
      end
    endcase
    return w;
  endfunction

  // entry step for each operation code
  function automatic upc_t dispatch(logic [MODE_W-1:0] mode);
    upc_t t;
    unique case (mode)
      MODE_CLEAR:  t = U_CLR;
      MODE_INSERT: t = U_INS;
      MODE_DRAIN:  t = U_DRN;
      default:     t = U_IDLE;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/bounded_max_heap_top_k.sv
// channel   dir  handshake              payload (low bit up)
// s_*       in   s_tvalid / s_tready    tuser: mode; tdata: sample_index, distance
// m_*       out  m_tvalid / m_tready    tuser: status; tdata: entry_index,
//                                       entry_distance, fill_count; tlast: last
// cfg_*     in   cfg_valid / cfg_ready  cfg_data: capacity
//
// Steps after the idle step that takes an item: clear clears; insert reads the
// root, then discards, or appends and climbs by parent compares level by level,
// or replaces the root and sinks by child compares; drain reads out each entry.
// Input is taken only in the idle step; a step that may emit stalls while
// the output register still holds a result that was not yet transferred.
// Synchronous reset empties the heap, sets capacity to 16; no clearing pass.
module bounded_max_heap_top_k #(
  parameter int MAX_K = bmh_pkg::MAX_K_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmh_pkg::CAP_W-1:0]      cfg_data,   // capacity
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bmh_pkg::S_TDATA_W-1:0]  s_tdata,    // sample_index, distance
  input  logic [bmh_pkg::MODE_W-1:0]     s_tuser,    // mode
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bmh_pkg::M_TDATA_W-1:0]  m_tdata,    // entry_index, entry_distance,
                                                     // fill_count, zero pad
  output logic [bmh_pkg::STAT_W-1:0]     m_tuser,    // status
  output logic                           m_tlast     // last
);

  localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int FW = $clog2(MAX_K + 1);
  localparam int CW = AW + 2;
  localparam int PAD_W = bmh_pkg::M_TDATA_W - bmh_pkg::IDX_W - bmh_pkg::DIST_W
                         - bmh_pkg::FILL_OUT_W;

  // heap storage
  bmh_pkg::entry_t mem [MAX_K];
  bmh_pkg::entry_t rd_a;
  bmh_pkg::entry_t rd_b;

  // sequencer and datapath registers
  bmh_pkg::upc_t              pc;
  logic [FW-1:0]              fill;
  logic [bmh_pkg::CAP_W-1:0]  cap;
  logic [AW-1:0]              slot;
  logic [AW-1:0]              pa;
  logic [AW-1:0]              l_addr;
  logic [AW-1:0]              r_addr;
  logic                       l_ok;
  logic                       r_ok;
  bmh_pkg::entry_t            x;

  // output register
  bmh_pkg::status_t               o_status;
  logic [bmh_pkg::IDX_W-1:0]      o_idx;
  logic [bmh_pkg::DIST_W-1:0]     o_dist;
  logic [bmh_pkg::FILL_OUT_W-1:0] o_fill;
  logic                           o_last;

  // combinational control
  bmh_pkg::uword_t   uw;
  bmh_pkg::upc_t     pc_next;
  logic [FW-1:0]     fill_next;
  logic [FW-1:0]     eff_cap;
  logic              out_free;
  logic              hold;
  logic              in_acc;
  logic              hit;
  logic              emit;
  bmh_pkg::status_t  st;
  bmh_pkg::wr_op_t   wr_op;
  bmh_pkg::ix_op_t   ia;
  bmh_pkg::fill_op_t fa;
  logic              pick_l;
  logic              pick_r;
  bmh_pkg::entry_t   big_ent;
  logic [AW-1:0]     big_addr;
  logic [AW-1:0]     parent;
  logic [CW-1:0]     lc;
  logic [CW-1:0]     rc;
  logic [AW-1:0]     ra;
  logic [AW-1:0]     rb;
  logic              rd_en;
  logic              we;
  bmh_pkg::entry_t   wd;

  assign cfg_ready = 1'b1;
  assign s_tready  = (pc == bmh_pkg::U_IDLE);
  assign m_tdata   = {{PAD_W{1'b0}}, o_fill, o_dist, o_idx};
  assign m_tuser   = o_status;
  assign m_tlast   = o_last;

  // effective capacity, clamped to 1..MAX_K
  always_comb begin
    if (cap == '0) begin
      eff_cap = FW'(1);
    end else if (32'(cap) > MAX_K) begin
      eff_cap = FW'(MAX_K);
    end else begin
      eff_cap = FW'(cap);
    end
  end

  // heap neighbor addresses
  assign parent = AW'((slot - AW'(1)) >> 1);
  assign lc     = CW'({slot, 1'b1});
  assign rc     = lc + CW'(1);

  // larger child against the held entry, left checked first
  always_comb begin
    pick_l   = l_ok && (rd_a.distance > x.distance);
    pick_r   = r_ok && (rd_b.distance > (pick_l ? rd_a.distance : x.distance));
    big_ent  = pick_r ? rd_b : rd_a;
    big_addr = pick_r ? r_addr : l_addr;
  end

  // decode the current control word
  always_comb begin
    uw       = bmh_pkg::ucode(pc);
    out_free = !m_tvalid || m_tready;
    hold     = uw.need_out && !out_free;
    in_acc   = s_tvalid && s_tready;

    unique case (uw.cond)
      bmh_pkg::C_ALWAYS: hit = 1'b1;
      bmh_pkg::C_IN:     hit = in_acc;
      bmh_pkg::C_APPEND: hit = (fill < eff_cap);
      bmh_pkg::C_IZERO:  hit = (slot == '0);
      bmh_pkg::C_PLT:    hit = (rd_a.distance < x.distance);
      bmh_pkg::C_RLT:    hit = (x.distance < rd_a.distance);
      bmh_pkg::C_DNSWAP: hit = pick_l || pick_r;
      bmh_pkg::C_EMPTY:  hit = (fill == '0);
      bmh_pkg::C_DLAST:  hit = ((FW'(slot) + FW'(1)) == fill);
      default:           hit = 1'b0;
    endcase

    wr_op = hit ? uw.wr_hit : uw.wr_miss;
    ia    = hit ? uw.ia_hit : uw.ia_miss;
    fa    = hit ? uw.fa_hit : bmh_pkg::FA_NONE;
    emit  = hit ? uw.emit_hit : uw.emit_miss;
    st    = hit ? uw.st_hit : uw.st_miss;

    // fill after this step
    unique case (fa)
      bmh_pkg::FA_CLEAR: fill_next = '0;
      bmh_pkg::FA_INC:   fill_next = fill + FW'(1);
      default:           fill_next = fill;
    endcase

    // step sequencing
    if (uw.disp && in_acc) begin
      pc_next = bmh_pkg::dispatch(s_tuser);
    end else if (hit) begin
      pc_next = uw.jmp;
    end else begin
      pc_next = uw.nxt;
    end

    // memory read addresses
    unique case (uw.rd)
      bmh_pkg::RD_ROOT:   ra = '0;
      bmh_pkg::RD_PARENT: ra = parent;
      bmh_pkg::RD_KIDS:   ra = lc[AW-1:0];
      bmh_pkg::RD_SLOT:   ra = slot;
      default:            ra = '0;
    endcase
    rb    = rc[AW-1:0];
    rd_en = !hold && (uw.rd != bmh_pkg::RD_NONE);

    // memory write at the hole
    we = !hold && (wr_op != bmh_pkg::WR_NONE);
    unique case (wr_op)
      bmh_pkg::WR_PAR: wd = rd_a;
      bmh_pkg::WR_BIG: wd = big_ent;
      default:         wd = x;
    endcase
  end

  // heap memory, registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[slot] <= wd;
    end
    if (rd_en) begin
      rd_a <= mem[ra];
      rd_b <= mem[rb];
    end
  end

  // sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= bmh_pkg::U_IDLE;
      fill     <= '0;
      cap      <= bmh_pkg::CAP_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      if (!hold) begin
        pc   <= pc_next;
        fill <= fill_next;
      end
      if (!hold && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x <= s_tdata;
    end
    if (!hold) begin
      // slot pointer
      if (wr_op == bmh_pkg::WR_PAR) begin
        slot <= pa;
      end else if (wr_op == bmh_pkg::WR_BIG) begin
        slot <= big_addr;
      end else begin
        case (ia)
          bmh_pkg::IX_ZERO: slot <= '0;
          bmh_pkg::IX_FILL: slot <= AW'(fill);
          bmh_pkg::IX_INC:  slot <= slot + AW'(1);
          default:          slot <= slot;
        endcase
      end
      // neighbor addresses that go with the read data
      if (uw.rd != bmh_pkg::RD_NONE) begin
        pa     <= parent;
        l_addr <= lc[AW-1:0];
        r_addr <= rc[AW-1:0];
        l_ok   <= (lc < CW'(fill));
        r_ok   <= (rc < CW'(fill));
      end
      // result load
      if (emit) begin
        o_status <= st;
        o_idx    <= uw.drn ? rd_a.idx : '0;
        o_dist   <= uw.drn ? rd_a.distance : '0;
        o_fill   <= bmh_pkg::FILL_OUT_W'(fill_next);
        o_last   <= uw.drn ? hit : 1'b1;
      end
    end
  end

endmodule
